// File: sv/assert_macros.svh
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define WLRF_ASSERT_NOW(lbl, clk, rst, pre, post, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// next-cycle implication
`define WLRF_ASSERT_NEXT(lbl, clk, rst, pre, post, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

// File: sv/wlrf_pkg.sv
package wlrf_pkg;

   // ring buffer geometry
   localparam int MAX_WINDOW  = 256;
   localparam int PTR_BITS    = 8;
   localparam int SAMPLE_BITS = 32;
   localparam logic [8:0] SEEN_LIMIT  = 9'd256;
   localparam logic [8:0] WLEN_MIN    = 9'd3;
   localparam logic [8:0] WLEN_MAX    = 9'd256;
   localparam logic [8:0] WLEN_RESET  = 9'd32;

   // csr map
   localparam int   CSR_ADDR_BITS  = 3;
   localparam logic CSR_IDX_WINDOW = 1'b0;

   // arithmetic constants
   localparam logic [6:0]  PCT_SCALE       = 7'd100;
   localparam logic [5:0]  MUL_LAST        = 6'd63;
   localparam logic [5:0]  DIV_TOP         = 6'd34;
   localparam logic [33:0] QUALITY_LIMIT   = 34'd65536;
   localparam logic [33:0] SLOPE_POS_LIMIT = 34'h07FFFFFFF;
   localparam logic [33:0] SLOPE_NEG_LIMIT = 34'h080000000;
   localparam logic [16:0] QUALITY_ONE     = 17'd65536;

   // fit job handed from front to back
   typedef struct packed {
      logic       ok;
      logic [7:0] start;
      logic [8:0] n;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef struct packed {
      logic        we;
      logic [7:0]  addr;
      logic [31:0] data;
   } ring_write_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_WALK,
      BK_DRAIN,
      BK_CALC_D,
      BK_MUL,
      BK_DIV,
      BK_RESP
   } back_state_type;

   typedef enum logic [2:0] {
      OP_NT,
      OP_SXS,
      OP_NQ,
      OP_SS,
      OP_NN,
      OP_DV,
      OP_KN,
      OP_DS
   } mul_op_type;

endpackage

// File: sv/wlrf_req_if.sv
interface wlrf_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] sample_value;
   logic               series_end;

   modport source (output valid, sample_value, series_end, input ready);
   modport sink   (input valid, sample_value, series_end, output ready);
endinterface

// File: sv/wlrf_rsp_if.sv
interface wlrf_rsp_if;
   logic               valid;
   logic               ready;
   logic               fit_valid;
   logic [16:0]        fit_quality;
   logic signed [31:0] slope_percent;

   modport source (output valid, fit_valid, fit_quality, slope_percent, input ready);
   modport sink   (input valid, fit_valid, fit_quality, slope_percent, output ready);
endinterface

// File: sv/window_linear_regression_fit.sv
// Samples are taken one per cycle into a 256-entry ring while no fit is pending.
// A series-end sample starts a fit over the last n samples for a window of n:
// a walk of the ring read port, then eight shift-add products and
// two restoring divisions; new samples wait until the result is taken.
// Reset clears pointers, counters and the fit sequencer and sets window_length to 32;
// ring contents are left as they are and are only read after being written.
module window_linear_regression_fit (
   input  logic                              clock,
   input  logic                              reset,
   wlrf_req_if.sink                          req_chan,
   wlrf_rsp_if.source                        rsp_chan,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [wlrf_pkg::CSR_ADDR_BITS-1:0] paddr,
   input  logic [31:0]                       pwdata,
   output logic [31:0]                       prdata,
   output logic                              pready
);

   logic [8:0]                 window_ff, window_in;
   logic                       csr_write;
   wlrf_pkg::ring_write_type   ring_wr;
   wlrf_pkg::queue_status_type q_status;
   wlrf_pkg::job_type          push_job, head_job;
   logic                       job_push, job_pop, fit_done;
   logic                       ring_re;
   logic [7:0]                 ring_raddr;
   logic [31:0]                ring_rdata;

   // csr write and read
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready &&
                      (paddr[2] == wlrf_pkg::CSR_IDX_WINDOW);
   assign window_in = csr_write ? pwdata[8:0] : window_ff;
   assign prdata    = (paddr[2] == wlrf_pkg::CSR_IDX_WINDOW) ? {23'd0, window_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= wlrf_pkg::WLEN_RESET;
      end else begin
         window_ff <= window_in;
      end
   end

   wlrf_ram #(
      .WIDTH (wlrf_pkg::SAMPLE_BITS),
      .DEPTH (wlrf_pkg::MAX_WINDOW)
   ) u_ring (
      .clock (clock),
      .we    (ring_wr.we),
      .waddr (ring_wr.addr),
      .wdata (ring_wr.data),
      .re    (ring_re),
      .raddr (ring_raddr),
      .rdata (ring_rdata)
   );

   wlrf_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_chan      (req_chan),
      .window_length (window_ff),
      .q_status      (q_status),
      .fit_done      (fit_done),
      .ring_wr       (ring_wr),
      .job_push      (job_push),
      .job_data      (push_job)
   );

   wlrf_job_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data (push_job),
      .pop       (job_pop),
      .head      (head_job),
      .status    (q_status)
   );

   wlrf_back u_back (
      .clock      (clock),
      .reset      (reset),
      .job_head   (head_job),
      .q_status   (q_status),
      .job_pop    (job_pop),
      .ring_re    (ring_re),
      .ring_raddr (ring_raddr),
      .ring_rdata (ring_rdata),
      .rsp_chan   (rsp_chan),
      .fit_done   (fit_done)
   );

endmodule

// File: sv/wlrf_ram.sv
module wlrf_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// File: sv/wlrf_front.sv
module wlrf_front (
   input  logic                      clock,
   input  logic                      reset,
   wlrf_req_if.sink                  req_chan,
   input  logic [8:0]                window_length,
   input  wlrf_pkg::queue_status_type q_status,
   input  logic                      fit_done,
   output wlrf_pkg::ring_write_type  ring_wr,
   output logic                      job_push,
   output wlrf_pkg::job_type         job_data
);

   logic [7:0] wp_ff, wp_in;
   logic [8:0] seen_ff, seen_in;
   logic       pending_ff, pending_in;
   logic       accept;
   logic [7:0] wp_inc;
   logic [8:0] seen_inc;

   // hold off new samples while a fit owns the ring
   assign req_chan.ready = !pending_ff && !q_status.full;
   assign accept = req_chan.valid && req_chan.ready;

   always_comb begin
      wp_inc   = wp_ff + 8'd1;
      seen_inc = (seen_ff < wlrf_pkg::SEEN_LIMIT) ? seen_ff + 9'd1 : seen_ff;
      wp_in      = accept ? wp_inc : wp_ff;
      seen_in    = seen_ff;
      pending_in = pending_ff;
      if (accept) begin
         seen_in = req_chan.series_end ? 9'd0 : seen_inc;
      end
      if (fit_done) begin
         pending_in = 1'b0;
      end
      if (accept && req_chan.series_end) begin
         pending_in = 1'b1;
      end
   end

   // ring write and job build
   always_comb begin
      ring_wr.we    = accept;
      ring_wr.addr  = wp_ff;
      ring_wr.data  = req_chan.sample_value;
      job_push      = accept && req_chan.series_end;
      job_data.ok   = (window_length >= wlrf_pkg::WLEN_MIN) &&
                      (window_length <= wlrf_pkg::WLEN_MAX) &&
                      (window_length <= seen_inc);
      job_data.start = wp_inc - window_length[7:0];
      job_data.n     = window_length;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff      <= 8'd0;
         seen_ff    <= 9'd0;
         pending_ff <= 1'b0;
      end else begin
         wp_ff      <= wp_in;
         seen_ff    <= seen_in;
         pending_ff <= pending_in;
      end
   end

endmodule

// File: sv/wlrf_job_queue.sv
module wlrf_job_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  wlrf_pkg::job_type          push_data,
   input  logic                       pop,
   output wlrf_pkg::job_type          head,
   output wlrf_pkg::queue_status_type status
);

   wlrf_pkg::job_type slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign status.full  = (count_ff == 2'd2);
   assign status.empty = (count_ff == 2'd0);
   assign head         = slot_ff[rd_ptr_ff];

   always_comb begin
      do_push   = push && !status.full;
      do_pop    = pop && !status.empty;
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// File: sv/wlrf_back.sv
module wlrf_back (
   input  logic                       clock,
   input  logic                       reset,
   input  wlrf_pkg::job_type          job_head,
   input  wlrf_pkg::queue_status_type q_status,
   output logic                       job_pop,
   output logic                       ring_re,
   output logic [7:0]                 ring_raddr,
   input  logic [31:0]                ring_rdata,
   wlrf_rsp_if.source                 rsp_chan,
   output logic                       fit_done
);

   wlrf_pkg::back_state_type state_ff, state_in;
   wlrf_pkg::mul_op_type     op_ff, op_in;
   wlrf_pkg::job_type        job_ff, job_in;

   // window walk pipeline
   logic [7:0]         i_ff, i_in;
   logic               rdv_ff, rdv_in;
   logic [7:0]         idx1_ff, idx1_in;
   logic               pv_ff, pv_in;
   logic signed [31:0] y2_ff, y2_in;
   logic [63:0]        yy_ff, yy_in;
   logic signed [39:0] yi_ff, yi_in;
   logic [7:0]         i2_ff, i2_in;
   logic [15:0]        ii_ff, ii_in;

   // exact sums
   logic signed [39:0] s_ff, s_in;
   logic signed [47:0] t_ff, t_in;
   logic [70:0]        q_ff, q_in;
   logic [14:0]        sx_ff, sx_in;
   logic [22:0]        sxx_ff, sxx_in;
   logic [31:0]        d_ff, d_in;

   // shift-add multiplier
   logic [143:0] ma_ff, ma_in;
   logic [63:0]  mb_ff, mb_in;
   logic [143:0] acc_ff, acc_in;
   logic [5:0]   mcnt_ff, mcnt_in;
   logic         mstart_ff, mstart_in;

   // products
   logic [55:0]  nt_ff, nt_in;
   logic [55:0]  sxs_ff, sxs_in;
   logic [79:0]  nq_ff, nq_in;
   logic [79:0]  ss_ff, ss_in;
   logic [111:0] nn_ff, nn_in;
   logic [107:0] dv_ff, dv_in;
   logic [86:0]  kn_ff, kn_in;
   logic [67:0]  ds_ff, ds_in;

   // restoring divider
   logic [143:0] rem_ff, rem_in;
   logic [143:0] dsh_ff, dsh_in;
   logic [33:0]  quo_ff, quo_in;
   logic [5:0]   dcnt_ff, dcnt_in;
   logic         dsel_ff, dsel_in;
   logic         dstart_ff, dstart_in;

   // result register
   logic               fvalid_ff, fvalid_in;
   logic [16:0]        quality_ff, quality_in;
   logic signed [31:0] slope_ff, slope_in;

   // derived values
   logic               s_neg, t_neg, n_neg, s_pos, v_pos;
   logic [39:0]        s_abs;
   logic [47:0]        t_abs;
   logic [57:0]        snt, ssxs, n_sig, n_mag;
   logic [56:0]        n_abs;
   logic [80:0]        v_sig;
   logic [79:0]        v_abs;
   logic [15:0]        n100;
   logic [30:0]        kfac;
   logic [79:0]        op_a;
   logic [63:0]        op_b;
   logic [143:0]       acc_step;
   logic               mul_last;
   logic signed [40:0] yi_mul;
   logic signed [63:0] yy_mul;
   logic [31:0]        nsxx;
   logic [29:0]        sxsq;
   logic [143:0]       div_num, div_den;
   logic               div_skip, div_ge, div_top, div_done;
   logic [33:0]        quo_step, lim, qfin;
   logic               last_issue, pop_now;

   // signs and magnitudes of the sums
   always_comb begin
      s_neg = s_ff[39];
      t_neg = t_ff[47];
      s_abs = s_neg ? -s_ff : s_ff;
      t_abs = t_neg ? -t_ff : t_ff;
      s_pos = !s_neg && (s_ff != 40'sd0);
      snt   = t_neg ? 58'd0 - {2'b0, nt_ff} : {2'b0, nt_ff};
      ssxs  = s_neg ? 58'd0 - {2'b0, sxs_ff} : {2'b0, sxs_ff};
      n_sig = snt - ssxs;
      n_neg = n_sig[57];
      n_mag = n_neg ? 58'd0 - n_sig : n_sig;
      n_abs = n_mag[56:0];
      v_sig = {1'b0, nq_ff} - {1'b0, ss_ff};
      v_pos = !v_sig[80] && (v_sig != 81'd0);
      v_abs = v_sig[79:0];
      n100  = job_ff.n * wlrf_pkg::PCT_SCALE;
      kfac  = {n100[14:0], 16'd0};
   end

   // multiplier operand select
   always_comb begin
      unique case (op_ff)
         wlrf_pkg::OP_NT: begin
            op_a = {32'd0, t_abs};
            op_b = {55'd0, job_ff.n};
         end
         wlrf_pkg::OP_SXS: begin
            op_a = {40'd0, s_abs};
            op_b = {49'd0, sx_ff};
         end
         wlrf_pkg::OP_NQ: begin
            op_a = {9'd0, q_ff};
            op_b = {55'd0, job_ff.n};
         end
         wlrf_pkg::OP_SS: begin
            op_a = {40'd0, s_abs};
            op_b = {24'd0, s_abs};
         end
         wlrf_pkg::OP_NN: begin
            op_a = {23'd0, n_abs};
            op_b = {7'd0, n_abs};
         end
         wlrf_pkg::OP_DV: begin
            op_a = v_abs;
            op_b = {32'd0, d_ff};
         end
         wlrf_pkg::OP_KN: begin
            op_a = {23'd0, n_abs};
            op_b = {33'd0, kfac};
         end
         wlrf_pkg::OP_DS: begin
            op_a = {40'd0, s_abs};
            op_b = {32'd0, d_ff};
         end
         default: begin
            op_a = 80'd0;
            op_b = 64'd0;
         end
      endcase
   end

   // step logic for multiplier, divider and walk
   always_comb begin
      acc_step   = mb_ff[0] ? acc_ff + ma_ff : acc_ff;
      mul_last   = (state_ff == wlrf_pkg::BK_MUL) && !mstart_ff &&
                   (mcnt_ff == wlrf_pkg::MUL_LAST);
      div_num    = dsel_ff ? {57'd0, kn_ff} : {16'd0, nn_ff, 16'd0};
      div_den    = dsel_ff ? {76'd0, ds_ff} : {36'd0, dv_ff};
      div_skip   = dsel_ff ? !s_pos : !v_pos;
      div_ge     = rem_ff >= dsh_ff;
      div_top    = (dcnt_ff == wlrf_pkg::DIV_TOP);
      quo_step   = {quo_ff[32:0], div_ge};
      div_done   = (state_ff == wlrf_pkg::BK_DIV) &&
                   (dstart_ff ? div_skip : ((div_top && div_ge) || (dcnt_ff == 6'd0)));
      lim        = dsel_ff ? (n_neg ? wlrf_pkg::SLOPE_NEG_LIMIT : wlrf_pkg::SLOPE_POS_LIMIT)
                           : wlrf_pkg::QUALITY_LIMIT;
      qfin       = (div_top || (quo_step > lim)) ? lim : quo_step;
      last_issue = ({1'b0, i_ff} == job_ff.n - 9'd1);
      pop_now    = (state_ff == wlrf_pkg::BK_IDLE) && !q_status.empty;
      yi_mul     = $signed(ring_rdata) * $signed({1'b0, idx1_ff});
      yy_mul     = $signed(ring_rdata) * $signed(ring_rdata);
      nsxx       = job_ff.n * sxx_ff;
      sxsq       = sx_ff * sx_ff;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         wlrf_pkg::BK_IDLE: begin
            if (!q_status.empty) begin
               state_in = job_head.ok ? wlrf_pkg::BK_WALK : wlrf_pkg::BK_RESP;
            end
         end
         wlrf_pkg::BK_WALK: begin
            if (last_issue) begin
               state_in = wlrf_pkg::BK_DRAIN;
            end
         end
         wlrf_pkg::BK_DRAIN: begin
            if (!rdv_ff && !pv_ff) begin
               state_in = wlrf_pkg::BK_CALC_D;
            end
         end
         wlrf_pkg::BK_CALC_D: state_in = wlrf_pkg::BK_MUL;
         wlrf_pkg::BK_MUL: begin
            if (mul_last && (op_ff == wlrf_pkg::OP_DS)) begin
               state_in = wlrf_pkg::BK_DIV;
            end
         end
         wlrf_pkg::BK_DIV: begin
            if (div_done && dsel_ff) begin
               state_in = wlrf_pkg::BK_RESP;
            end
         end
         wlrf_pkg::BK_RESP: begin
            if (rsp_chan.ready) begin
               state_in = wlrf_pkg::BK_IDLE;
            end
         end
         default: state_in = wlrf_pkg::BK_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      job_pop                = pop_now;
      ring_re                = (state_ff == wlrf_pkg::BK_WALK);
      ring_raddr             = job_ff.start + i_ff;
      rsp_chan.valid         = (state_ff == wlrf_pkg::BK_RESP);
      rsp_chan.fit_valid     = fvalid_ff;
      rsp_chan.fit_quality   = quality_ff;
      rsp_chan.slope_percent = slope_ff;
      fit_done               = (state_ff == wlrf_pkg::BK_RESP) && rsp_chan.ready;
   end

   // datapath next values
   always_comb begin
      job_in     = job_ff;
      op_in      = op_ff;
      i_in       = i_ff;
      rdv_in     = (state_ff == wlrf_pkg::BK_WALK);
      idx1_in    = i_ff;
      pv_in      = rdv_ff;
      y2_in      = ring_rdata;
      yy_in      = yy_mul;
      yi_in      = yi_mul[39:0];
      i2_in      = idx1_ff;
      ii_in      = idx1_ff * idx1_ff;
      s_in       = s_ff;
      t_in       = t_ff;
      q_in       = q_ff;
      sx_in      = sx_ff;
      sxx_in     = sxx_ff;
      d_in       = d_ff;
      ma_in      = ma_ff;
      mb_in      = mb_ff;
      acc_in     = acc_ff;
      mcnt_in    = mcnt_ff;
      mstart_in  = mstart_ff;
      nt_in      = nt_ff;
      sxs_in     = sxs_ff;
      nq_in      = nq_ff;
      ss_in      = ss_ff;
      nn_in      = nn_ff;
      dv_in      = dv_ff;
      kn_in      = kn_ff;
      ds_in      = ds_ff;
      rem_in     = rem_ff;
      dsh_in     = dsh_ff;
      quo_in     = quo_ff;
      dcnt_in    = dcnt_ff;
      dsel_in    = dsel_ff;
      dstart_in  = dstart_ff;
      fvalid_in  = fvalid_ff;
      quality_in = quality_ff;
      slope_in   = slope_ff;

      // accumulate one window sample
      if (pv_ff) begin
         s_in   = s_ff + {{8{y2_ff[31]}}, y2_ff};
         t_in   = t_ff + {{8{yi_ff[39]}}, yi_ff};
         q_in   = q_ff + {7'd0, yy_ff};
         sx_in  = sx_ff + {7'd0, i2_ff};
         sxx_in = sxx_ff + {7'd0, ii_ff};
      end

      unique case (state_ff)
         wlrf_pkg::BK_IDLE: begin
            if (pop_now) begin
               job_in     = job_head;
               i_in       = 8'd0;
               s_in       = 40'sd0;
               t_in       = 48'sd0;
               q_in       = 71'd0;
               sx_in      = 15'd0;
               sxx_in     = 23'd0;
               fvalid_in  = job_head.ok;
               quality_in = 17'd0;
               slope_in   = 32'sd0;
            end
         end
         wlrf_pkg::BK_WALK: i_in = i_ff + 8'd1;
         wlrf_pkg::BK_DRAIN: begin
         end
         // D = n*sum(x^2) - (sum x)^2, never zero for n >= 3
         wlrf_pkg::BK_CALC_D: begin
            d_in      = nsxx - {2'd0, sxsq};
            op_in     = wlrf_pkg::OP_NT;
            mstart_in = 1'b1;
         end
         wlrf_pkg::BK_MUL: begin
            if (mstart_ff) begin
               ma_in     = {64'd0, op_a};
               mb_in     = op_b;
               acc_in    = 144'd0;
               mcnt_in   = 6'd0;
               mstart_in = 1'b0;
            end else begin
               acc_in  = acc_step;
               ma_in   = {ma_ff[142:0], 1'b0};
               mb_in   = {1'b0, mb_ff[63:1]};
               mcnt_in = mcnt_ff + 6'd1;
               if (mul_last) begin
                  case (op_ff)
                     wlrf_pkg::OP_NT:  nt_in  = acc_step[55:0];
                     wlrf_pkg::OP_SXS: sxs_in = acc_step[55:0];
                     wlrf_pkg::OP_NQ:  nq_in  = acc_step[79:0];
                     wlrf_pkg::OP_SS:  ss_in  = acc_step[79:0];
                     wlrf_pkg::OP_NN:  nn_in  = acc_step[111:0];
                     wlrf_pkg::OP_DV:  dv_in  = acc_step[107:0];
                     wlrf_pkg::OP_KN:  kn_in  = acc_step[86:0];
                     default:          ds_in  = acc_step[67:0];
                  endcase
                  if (op_ff == wlrf_pkg::OP_DS) begin
                     dsel_in   = 1'b0;
                     dstart_in = 1'b1;
                  end else begin
                     op_in     = wlrf_pkg::mul_op_type'(op_ff + 3'd1);
                     mstart_in = 1'b1;
                  end
               end
            end
         end
         wlrf_pkg::BK_DIV: begin
            if (dstart_ff) begin
               rem_in    = div_num;
               dsh_in    = div_den << wlrf_pkg::DIV_TOP;
               quo_in    = 34'd0;
               dcnt_in   = wlrf_pkg::DIV_TOP;
               dstart_in = div_skip;
            end else begin
               dsh_in  = {1'b0, dsh_ff[143:1]};
               dcnt_in = dcnt_ff - 6'd1;
               if (!div_top) begin
                  rem_in = div_ge ? rem_ff - dsh_ff : rem_ff;
                  quo_in = quo_step;
               end
               if (div_done) begin
                  if (dsel_ff) begin
                     slope_in = n_neg ? -qfin[31:0] : qfin[31:0];
                  end else begin
                     quality_in = qfin[16:0];
                  end
               end
            end
            // quality done: start the slope division
            if (div_done && !dsel_ff) begin
               dsel_in   = 1'b1;
               dstart_in = 1'b1;
            end
         end
         wlrf_pkg::BK_RESP: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      job_ff     <= job_in;
      op_ff      <= op_in;
      i_ff       <= i_in;
      idx1_ff    <= idx1_in;
      y2_ff      <= y2_in;
      yy_ff      <= yy_in;
      yi_ff      <= yi_in;
      i2_ff      <= i2_in;
      ii_ff      <= ii_in;
      s_ff       <= s_in;
      t_ff       <= t_in;
      q_ff       <= q_in;
      sx_ff      <= sx_in;
      sxx_ff     <= sxx_in;
      d_ff       <= d_in;
      ma_ff      <= ma_in;
      mb_ff      <= mb_in;
      acc_ff     <= acc_in;
      mcnt_ff    <= mcnt_in;
      nt_ff      <= nt_in;
      sxs_ff     <= sxs_in;
      nq_ff      <= nq_in;
      ss_ff      <= ss_in;
      nn_ff      <= nn_in;
      dv_ff      <= dv_in;
      kn_ff      <= kn_in;
      ds_ff      <= ds_in;
      rem_ff     <= rem_in;
      dsh_ff     <= dsh_in;
      quo_ff     <= quo_in;
      dcnt_ff    <= dcnt_in;
      dsel_ff    <= dsel_in;
      fvalid_ff  <= fvalid_in;
      quality_ff <= quality_in;
      slope_ff   <= slope_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= wlrf_pkg::BK_IDLE;
         rdv_ff    <= 1'b0;
         pv_ff     <= 1'b0;
         mstart_ff <= 1'b0;
         dstart_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         rdv_ff    <= rdv_in;
         pv_ff     <= pv_in;
         mstart_ff <= mstart_in;
         dstart_ff <= dstart_in;
      end
   end

endmodule

// File: sv/wlrf_checker.sv
`include "assert_macros.svh"

module wlrf_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        req_series_end,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        fit_valid,
   input logic [16:0] fit_quality,
   input logic [31:0] slope_percent
);

   // a pending result stays offered
   `WLRF_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "result dropped before transaction")

   // a series end blocks further samples until its result is out
   `WLRF_ASSERT_NEXT(a_end_blocks, clock, reset, req_valid && req_ready && req_series_end, !req_ready, "sample taken during fit")

   // an invalid fit carries zero fields
   `WLRF_ASSERT_NOW(a_invalid_zero, clock, reset, rsp_valid && !fit_valid, (fit_quality == 17'd0) && (slope_percent == 32'd0), "invalid fit with nonzero fields")

   // quality never exceeds one
   `WLRF_ASSERT_NOW(a_quality_max, clock, reset, rsp_valid, fit_quality <= wlrf_pkg::QUALITY_ONE, "fit quality above one")

endmodule

bind window_linear_regression_fit wlrf_checker u_wlrf_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_chan.valid),
   .req_ready      (req_chan.ready),
   .req_series_end (req_chan.series_end),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .fit_valid      (rsp_chan.fit_valid),
   .fit_quality    (rsp_chan.fit_quality),
   .slope_percent  (rsp_chan.slope_percent)
);

// File: bench/tb_top.sv
module tb_top;

   localparam int STALL_MAX  = 8;
   localparam int IDLE_LIMIT = 20000;
   localparam int SETTLE     = 50;
   localparam logic [wlrf_pkg::CSR_ADDR_BITS-1:0] ADDR_WINDOW =
      {wlrf_pkg::CSR_IDX_WINDOW, 2'b00};

   typedef struct packed {
      logic        ok;
      logic [16:0] quality;
      logic [31:0] slope;
   } fit_rec_type;

   typedef struct {
      logic [31:0] value;
      logic        last;
      bit          typed;
      fit_rec_type fit;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset;
   logic psel, penable, pwrite;
   logic [wlrf_pkg::CSR_ADDR_BITS-1:0] paddr;
   logic [31:0] pwdata, prdata;
   logic pready;

   wlrf_req_if req_chan ();
   wlrf_rsp_if rsp_chan ();

   window_linear_regression_fit uut (
      .clock(clock), .reset(reset), .req_chan(req_chan.sink), .rsp_chan(rsp_chan.source),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // predictor state
   logic signed [31:0] ring_copy [wlrf_pkg::MAX_WINDOW];
   logic [7:0]  wptr_copy;
   logic [8:0]  seen_copy;
   logic [8:0]  wlen_copy;
   fit_rec_type expected_fits [$];

   int errors = 0;
   int samples_sent = 0;
   int fits_checked = 0;
   int settings_used = 0;
   int idle_cycles = 0;
   bit accepted_any;

   task automatic report(input string what);
      errors++;
      $display("mismatch: %s", what);
   endtask

   // store one sample, return 1 with the expected fit on a series end
   function automatic bit predict_sample(input logic signed [31:0] v, input logic last,
                                         output fit_rec_type r);
      logic signed [255:0] n, bi, y, s, t, q, sx, sxx, d, num_n, var_v, quo, lim, an;
      logic [7:0] idx;
      ring_copy[wptr_copy] = v;
      wptr_copy = wptr_copy + 8'd1;
      if (seen_copy < wlrf_pkg::SEEN_LIMIT) seen_copy = seen_copy + 9'd1;
      r = '0;
      if (!last) return 1'b0;
      n = wlen_copy;
      if (wlen_copy >= wlrf_pkg::WLEN_MIN && wlen_copy <= wlrf_pkg::WLEN_MAX &&
          wlen_copy <= seen_copy) begin
         s = 0; t = 0; q = 0;
         for (int i = 0; i < wlen_copy; i++) begin
            idx = wptr_copy - wlen_copy[7:0] + 8'(i);
            bi = i;
            y = ring_copy[idx];
            s = s + y;
            t = t + y * bi;
            q = q + y * y;
         end
         sx = n * (n - 1) / 2;
         sxx = (n - 1) * n * (2 * n - 1) / 6;
         d = n * sxx - sx * sx;
         if (d != 0) begin
            num_n = n * t - sx * s;
            var_v = n * q - s * s;
            r.ok = 1'b1;
            if (var_v > 0) begin
               quo = ((num_n * num_n) <<< 16) / (d * var_v);
               if (quo > 65536) quo = 65536;
               r.quality = quo[16:0];
            end
            if (s > 0) begin
               an = (num_n < 0) ? -num_n : num_n;
               lim = (num_n < 0) ? 256'sh80000000 : 256'sh7FFFFFFF;
               quo = (100 * n * 65536 * an) / (d * s);
               if (quo > lim) quo = lim;
               if (num_n < 0) quo = -quo;
               r.slope = quo[31:0];
            end
         end
      end
      seen_copy = 9'd0;
      return 1'b1;
   endfunction

   // csr write and readback
   task automatic csr_write(input logic [8:0] value);
      logic [31:0] rd;
      psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0; paddr <= ADDR_WINDOW;
      pwdata <= {23'd0, value};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      pwrite <= 1'b0; penable <= 1'b0;
      accepted_any = 1'b1;
      wlen_copy = value;
      settings_used++;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      rd = prdata;
      psel <= 1'b0; penable <= 1'b0;
      if (rd[8:0] !== value)
         report($sformatf("window_length read %0d, wrote %0d", rd[8:0], value));
   endtask

   // one sample transaction with a random lead-in gap
   bit req_burst = 1'b0;
   task automatic send_sample(input logic [31:0] v, input logic last, input bit typed,
                              input fit_rec_type typed_fit);
      int gap;
      fit_rec_type r;
      if ($urandom_range(0, 15) == 0) req_burst = !req_burst;
      gap = req_burst ? 0 : $urandom_range(0, STALL_MAX);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.sample_value <= v;
      req_chan.series_end <= last;
      do @(posedge clock); while (!req_chan.ready);
      accepted_any = 1'b1;
      samples_sent++;
      if (predict_sample(v, last, r)) expected_fits.push_back(typed ? typed_fit : r);
   endtask

   task automatic wait_idle();
      req_chan.valid <= 1'b0;
      while (expected_fits.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   function automatic logic [31:0] draw_value(input int style, input int i);
      case ($urandom_range(0, 9))
         0: return 32'h80000000;
         1: return 32'h7FFFFFFF;
         default: case (style)
            0: return $urandom;
            1: return 32'($urandom_range(0, 4095)) - 32'd2048;
            2: return 32'h00100000 + 32'(i) * 32'($urandom_range(0, 4096)) +
                      $urandom_range(0, 255);
            default: return 32'h40000000 - 32'(i) * 32'h00100000 +
                            $urandom_range(0, 65535);
         endcase
      endcase
   endfunction

   // result side: random stall, then compare against oldest expectation
   initial begin : result_sink
      int stall;
      bit burst;
      fit_rec_type want;
      burst = 1'b0;
      forever begin
         if ($urandom_range(0, 15) == 0) burst = !burst;
         stall = burst ? 0 : $urandom_range(0, STALL_MAX);
         if (stall > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_chan.valid === 1'b1) || reset);
         accepted_any = 1'b1;
         if (expected_fits.size() == 0) begin
            report("fit result with nothing expected");
         end else begin
            want = expected_fits.pop_front();
            fits_checked++;
            if (rsp_chan.fit_valid !== want.ok)
               report($sformatf("fit_valid %b exp %b", rsp_chan.fit_valid, want.ok));
            if (rsp_chan.fit_quality !== want.quality)
               report($sformatf("fit_quality %0d exp %0d", rsp_chan.fit_quality,
                                want.quality));
            if (rsp_chan.slope_percent !== want.slope)
               report($sformatf("slope_percent %h exp %h", rsp_chan.slope_percent,
                                want.slope));
         end
      end
   end

   // watchdog on cycles without any transaction
   always @(posedge clock) begin
      if (accepted_any || reset) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      accepted_any = 1'b0;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("watchdog expired with %0d fits outstanding", expected_fits.size());
         $display("status: fail");
         $finish;
      end
   end

   stim_row_type directed [$];
   int windows [8] = '{3, 256, 2, 0, 511, 257, 17, -1};

   task automatic add_row(input logic [31:0] v, input logic last, input bit typed,
                          input fit_rec_type f);
      stim_row_type row;
      row.value = v; row.last = last; row.typed = typed; row.fit = f;
      directed.push_back(row);
   endtask

   initial begin : stimulus
      fit_rec_type none, flat;
      int budget, len, style, w;
      logic [31:0] v;
      none = '0;
      flat = '{ok: 1'b1, quality: 17'd0, slope: 32'd0};
      reset <= 1'b1;
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0; paddr <= '0; pwdata <= '0;
      req_chan.valid <= 1'b0; req_chan.sample_value <= '0; req_chan.series_end <= 1'b0;
      wptr_copy = '0; seen_copy = '0; wlen_copy = wlrf_pkg::WLEN_RESET;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // after reset window 32: a lone marked sample is too few
      send_sample(32'h7FFFFFFF, 1'b1, 1'b1, none);
      wait_idle();
      csr_write(wlrf_pkg::WLEN_MIN);
      // constant negative extreme: flat window and non-positive mean
      repeat (2) add_row(32'h80000000, 1'b0, 1'b0, none);
      add_row(32'h80000000, 1'b1, 1'b1, flat);
      // constant positive extreme: flat window, zero slope
      repeat (2) add_row(32'h7FFFFFFF, 1'b0, 1'b0, none);
      add_row(32'h7FFFFFFF, 1'b1, 1'b1, flat);
      // exact line, quality one
      add_row(32'h00010000, 1'b0, 1'b0, none);
      add_row(32'h00020000, 1'b0, 1'b0, none);
      add_row(32'h00030000, 1'b1, 1'b0, none);
      // zero mean
      add_row(32'hFFFFFFFF, 1'b0, 1'b0, none);
      add_row(32'h00000000, 1'b0, 1'b0, none);
      add_row(32'h00000001, 1'b1, 1'b0, none);
      // alternating extremes
      add_row(32'h7FFFFFFF, 1'b0, 1'b0, none);
      add_row(32'h80000000, 1'b0, 1'b0, none);
      add_row(32'h7FFFFFFF, 1'b1, 1'b0, none);
      // falling positive series, negative slope
      add_row(32'h00300000, 1'b0, 1'b0, none);
      add_row(32'h00200000, 1'b0, 1'b0, none);
      add_row(32'h00000000, 1'b1, 1'b0, none);
      // too few in series after a series end
      add_row(32'h00050000, 1'b0, 1'b0, none);
      add_row(32'h00060000, 1'b1, 1'b1, none);
      foreach (directed[i]) send_sample(directed[i].value, directed[i].last,
                                        directed[i].typed, directed[i].fit);
      wait_idle();

      // random phases over several window settings
      foreach (windows[p]) begin
         w = (windows[p] < 0) ? $urandom_range(3, 64) : windows[p];
         csr_write(9'(w));
         budget = (w >= 3 && w <= 256) ? 60 : 20;
         while (budget > 0) begin
            case ($urandom_range(0, 9))
               0, 1: len = $urandom_range(1, (w > 256 || w < 3) ? 20 : w);
               2: len = $urandom_range(1, 300);
               default: len = ((w > 256 || w < 3) ? 8 : w) + $urandom_range(0, 4);
            endcase
            style = $urandom_range(0, 3);
            for (int i = 0; i < len; i++) begin
               v = draw_value(style, i);
               send_sample(v, i == len - 1, 1'b0, none);
            end
            budget -= len;
         end
         wait_idle();
      end

      $display("run covered %0d samples, %0d fits checked, %0d window settings",
               samples_sent, fits_checked, settings_used);
      if (errors == 0 && expected_fits.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("%0d mismatches", errors);
         $display("status: fail");
      end
      $finish;
   end
endmodule
